FILE: rtl/core/lrpw_pkg.sv
package lrpw_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ROW_PITCH  = 3'd0,
        REG_BPP        = 3'd1,
        REG_COLOR      = 3'd2,
        REG_BIG_ENDIAN = 3'd3,
        REG_WIDTH      = 3'd4,
        REG_HEIGHT     = 3'd5,
        REG_BASE       = 3'd6
    } reg_index_t;

    // One pixel job handed from the line front end to the pixel back end.
    // Widths cover every supported fraction width.
    typedef struct packed {
        logic signed [15:0] low_minor;
        logic        [15:0] len;
        logic signed [18:0] pdiff;
        logic signed [16:0] dminor;
        logic signed [17:0] major;
        logic               steep;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [15:0] row_pitch;
        logic [2:0]  bpp;
        logic [31:0] color;
        logic        big_endian;
        logic [11:0] width;
        logic [11:0] height;
        logic [31:0] base;
    } cfg_t;

endpackage

FILE: rtl/core/lrpw_queue.sv
module lrpw_queue
    import lrpw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t push_job,
    input  logic push_valid,
    output logic push_ready,
    output job_t pop_job,
    output logic pop_valid,
    input  logic pop_ready
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/lrpw_front.sv
module lrpw_front
    import lrpw_pkg::*;
#(
    parameter int FRAC_BITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    output job_t               job,
    output logic               job_valid,
    input  logic               job_ready
);

    logic               active_reg;
    logic               steep_reg;
    logic signed [17:0] major_reg;
    logic signed [15:0] lm_reg, lmin_reg, hm_reg, hmin_reg;

    logic signed [16:0] dx, dy, adx, ady;
    logic               steep_n, swap_n;
    logic signed [15:0] a0, a1, b0, b1;
    logic signed [15:0] lm_n, lmin_n, hm_n, hmin_n;
    logic        [16:0] lm_mag;
    logic        [16:0] mag_sh;
    logic signed [17:0] trunc_n;
    logic signed [26:0] trunc_scaled;
    logic               active_n;

    logic signed [16:0] len_w;
    logic               zero_len;
    logic signed [26:0] pos_scaled;
    logic signed [26:0] pdiff_w;
    logic signed [26:0] next_scaled;
    logic               last;
    logic               accept;

    assign in_ready = job_ready;
    assign accept   = in_valid && in_ready;

    // Loading a line: choose the major axis, then order the endpoints.
    always_comb
    begin
        dx      = 17'(start_x) - 17'(end_x);
        dy      = 17'(start_y) - 17'(end_y);
        adx     = dx[16] ? -dx : dx;
        ady     = dy[16] ? -dy : dy;
        steep_n = adx < ady;
        a0      = steep_n ? start_y : start_x;
        a1      = steep_n ? start_x : start_y;
        b0      = steep_n ? end_y : end_x;
        b1      = steep_n ? end_x : end_y;
        swap_n  = a0 > b0;
        lm_n    = swap_n ? b0 : a0;
        lmin_n  = swap_n ? b1 : a1;
        hm_n    = swap_n ? a0 : b0;
        hmin_n  = swap_n ? a1 : b1;
        // Truncate the low major endpoint toward zero.
        lm_mag  = 17'(-17'(lm_n));
        mag_sh  = lm_mag >> FRAC_BITS;
        if (lm_n[15])
        begin
            trunc_n = -$signed({1'b0, mag_sh});
        end
        else
        begin
            trunc_n = 18'(lm_n) >>> FRAC_BITS;
        end
        trunc_scaled = 27'(trunc_n) <<< FRAC_BITS;
        active_n = ((lm_n == hm_n) && (lmin_n == hmin_n)) || (trunc_scaled <= 27'(hm_n));
    end

    // Stepping: the operands of the interpolation for the current pixel.
    always_comb
    begin
        len_w       = 17'(hm_reg) - 17'(lm_reg);
        zero_len    = (len_w == 17'sd0);
        pos_scaled  = 27'(major_reg) <<< FRAC_BITS;
        pdiff_w     = pos_scaled - 27'(lm_reg);
        next_scaled = (27'(major_reg) + 27'sd1) <<< FRAC_BITS;
        last        = zero_len || (next_scaled > 27'(hm_reg));

        job.low_minor = lmin_reg;
        job.len       = zero_len ? 16'd1 : len_w[15:0];
        job.pdiff     = zero_len ? 19'sd0 : pdiff_w[18:0];
        job.dminor    = zero_len ? 17'sd0 : 17'(hmin_reg) - 17'(lmin_reg);
        job.major     = major_reg;
        job.steep     = steep_reg;
        job.last      = last;
    end

    assign job_valid = in_valid && req_type && active_reg;

    always_ff @(posedge clk)
    begin
        if (accept && !req_type)
        begin
            lm_reg   <= lm_n;
            lmin_reg <= lmin_n;
            hm_reg   <= hm_n;
            hmin_reg <= hmin_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            steep_reg  <= 1'b0;
            major_reg  <= 18'sd0;
        end
        else if (accept)
        begin
            if (!req_type)
            begin
                active_reg <= active_n;
                steep_reg  <= steep_n;
                major_reg  <= trunc_n;
            end
            else if (active_reg)
            begin
                if (last)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    major_reg <= major_reg + 18'sd1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/lrpw_back.sv
module lrpw_back
    import lrpw_pkg::*;
#(
    parameter int FRAC_BITS = 4,
    parameter int INT_BITS  = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  job_t               job,
    input  logic               job_valid,
    output logic               job_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] pixel_x,
    output logic signed [11:0] pixel_y,
    output logic        [31:0] byte_address,
    output logic        [31:0] write_bytes,
    output logic        [2:0]  byte_count,
    output logic               off_frame,
    output logic               last_pixel
);

    localparam int QW   = 17 - FRAC_BITS;
    localparam int NW   = 38;
    localparam int CNTW = $clog2(QW);
    localparam logic signed [17:0] SAT_HI = 18'((1 << (INT_BITS - 1)) - 1);
    localparam logic signed [17:0] SAT_LO = -SAT_HI - 18'sd1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_MUL1 = 8'b00000010,
        ST_MUL2 = 8'b00000100,
        ST_PREP = 8'b00001000,
        ST_DIV  = 8'b00010000,
        ST_POS  = 8'b00100000,
        ST_ADDR = 8'b01000000,
        ST_PUT  = 8'b10000000
    } state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic signed [32:0] prod1_reg;
    logic signed [35:0] prod2_reg;
    logic [NW-1:0]      rem_reg;
    logic [NW-1:0]      dsh_reg;
    logic [QW-1:0]      quo_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               neg_reg;
    logic signed [17:0] px_reg, py_reg;
    logic               off_reg;
    logic [27:0]        yprod_reg;
    logic [13:0]        xoff_reg;

    logic               out_valid_reg;
    logic [11:0]        pixel_x_reg, pixel_y_reg;
    logic [31:0]        byte_address_reg, write_bytes_reg;
    logic [2:0]         byte_count_reg;
    logic               off_frame_reg, last_pixel_reg;

    logic signed [36:0] num;
    logic [36:0]        mag;
    logic [23:0]        den;
    logic               ge;
    logic signed [17:0] minor;
    logic [2:0]         bpp_eff;
    logic [31:0]        lanes;
    logic               out_free;

    function automatic logic [11:0] sat12(input logic signed [17:0] v);
        logic signed [17:0] c;
        begin
            c = v;
            if (c < SAT_LO)
            begin
                c = SAT_LO;
            end
            if (c > SAT_HI)
            begin
                c = SAT_HI;
            end
            return c[11:0];
        end
    endfunction

    assign job_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        num   = 37'(prod1_reg) + 37'(prod2_reg);
        mag   = num[36] ? 37'(-num) : 37'(num);
        den   = 24'(job_reg.len) << FRAC_BITS;
        ge    = rem_reg >= dsh_reg;
        minor = neg_reg ? -18'($unsigned(quo_reg)) : 18'($unsigned(quo_reg));
        if (cfg.bpp == 3'd0)
        begin
            bpp_eff = 3'd1;
        end
        else if (cfg.bpp > 3'd4)
        begin
            bpp_eff = 3'd4;
        end
        else
        begin
            bpp_eff = cfg.bpp;
        end
        case (bpp_eff)
            3'd1:    lanes = {24'd0, cfg.color[7:0]};
            3'd2:    lanes = {16'd0, cfg.color[15:0]};
            3'd3:    lanes = cfg.big_endian ?
                             {8'd0, cfg.color[7:0], cfg.color[15:8], cfg.color[23:16]} :
                             {8'd0, cfg.color[23:0]};
            default: lanes = cfg.color;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
            end
            ST_MUL1:
            begin
                prod1_reg <= job_reg.low_minor * $signed({1'b0, job_reg.len});
            end
            ST_MUL2:
            begin
                prod2_reg <= job_reg.pdiff * job_reg.dminor;
            end
            ST_PREP:
            begin
                // Round half away from zero: (2|n| + d) / (2d).
                neg_reg <= num[36];
                rem_reg <= NW'({mag, 1'b0}) + NW'(den);
                dsh_reg <= NW'(den) << QW;
                quo_reg <= '0;
                cnt_reg <= CNTW'(QW - 1);
            end
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[QW-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            ST_POS:
            begin
                px_reg <= job_reg.steep ? minor : job_reg.major;
                py_reg <= job_reg.steep ? job_reg.major : minor;
            end
            ST_ADDR:
            begin
                off_reg   <= px_reg < 18'sd0 || px_reg >= $signed({6'd0, cfg.width}) ||
                             py_reg < 18'sd0 || py_reg >= $signed({6'd0, cfg.height});
                yprod_reg <= py_reg[11:0] * cfg.row_pitch;
                xoff_reg  <= px_reg[11:0] * bpp_eff;
            end
            default:
            begin
            end
        endcase
    end

    // The rounding divisor is 2*den, so den << QW is that divisor aligned
    // with the top quotient bit; QW compare-and-subtract steps follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE: if (job_valid) state_reg <= ST_MUL1;
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_PREP;
                ST_PREP: state_reg <= ST_DIV;
                ST_DIV:  if (cnt_reg == '0) state_reg <= ST_POS;
                ST_POS:  state_reg <= ST_ADDR;
                ST_ADDR: state_reg <= ST_PUT;
                ST_PUT:  if (out_free) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PUT && out_free)
        begin
            pixel_x_reg      <= sat12(px_reg);
            pixel_y_reg      <= sat12(py_reg);
            byte_address_reg <= off_reg ? 32'd0 :
                                cfg.base + 32'(yprod_reg) + 32'(xoff_reg);
            write_bytes_reg  <= off_reg ? 32'd0 : lanes;
            byte_count_reg   <= bpp_eff;
            off_frame_reg    <= off_reg;
            last_pixel_reg   <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_PUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign byte_address = byte_address_reg;
    assign write_bytes  = write_bytes_reg;
    assign byte_count   = byte_count_reg;
    assign off_frame    = off_frame_reg;
    assign last_pixel   = last_pixel_reg;

    a_put_shows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT && out_free |=> out_valid_reg)
        else $error("finished pixel not presented");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> byte_count_reg >= 3'd1 && byte_count_reg <= 3'd4)
        else $error("byte count out of range");

    a_off_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && off_frame_reg |-> byte_address_reg == 32'd0 &&
        write_bytes_reg == 32'd0)
        else $error("off-frame pixel carries a write");

    a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> state_reg == ST_MUL1)
        else $error("taken job did not start");

endmodule

FILE: rtl/core/line_rasterizer_pixel_writer.sv
// Start requests produce no output.
// Each step request of an active line yields one pixel, computed in the
// back end by two multiplies, a one-bit-per-cycle rounding divider and
// the position and address states; the back end takes a new pixel only
// when idle, once the previous one has gone to its output register.
// A two-entry queue lets the front take requests while the back end works.
// Reset (asynchronous, active low) clears the line, queue and output valid.
module line_rasterizer_pixel_writer
    import lrpw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 4,
    parameter int COORD_INT_BITS  = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] pixel_x,
    output logic signed [11:0] pixel_y,
    output logic        [31:0] byte_address,
    output logic        [31:0] write_bytes,
    output logic        [2:0]  byte_count,
    output logic               off_frame,
    output logic               last_pixel
);

    cfg_t cfg_reg;
    job_t front_job, back_job;
    logic front_valid, front_ready, back_valid, back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_pitch  <= 16'd2560;
            cfg_reg.bpp        <= 3'd4;
            cfg_reg.color      <= 32'h00FF00FF;
            cfg_reg.big_endian <= 1'b0;
            cfg_reg.width      <= 12'd640;
            cfg_reg.height     <= 12'd480;
            cfg_reg.base       <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_PITCH:  cfg_reg.row_pitch  <= cfg_data[15:0];
                REG_BPP:        cfg_reg.bpp        <= cfg_data[2:0];
                REG_COLOR:      cfg_reg.color      <= cfg_data;
                REG_BIG_ENDIAN: cfg_reg.big_endian <= cfg_data[0];
                REG_WIDTH:      cfg_reg.width      <= cfg_data[11:0];
                REG_HEIGHT:     cfg_reg.height     <= cfg_data[11:0];
                REG_BASE:       cfg_reg.base       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lrpw_front #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    lrpw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    lrpw_back #(
        .FRAC_BITS (COORD_FRAC_BITS),
        .INT_BITS  (COORD_INT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job          (back_job),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .byte_address (byte_address),
        .write_bytes  (write_bytes),
        .byte_count   (byte_count),
        .off_frame    (off_frame),
        .last_pixel   (last_pixel)
    );

endmodule
